// ----- design/sgfc_pkg.sv -----
// Shared types and constants for the sync gap fill checker.
// No dependencies; every other design file refers to it by scoped names.
package sgfc_pkg;

    localparam logic [7:0] SYNC_BYTE  = 8'hFF;
    localparam logic [7:0] TRAIL_BYTE = 8'h67;

    localparam logic [7:0] SYNC_MIN_FLOOR = 8'd2;

    localparam logic [7:0] RST_SYNC_MIN_LENGTH = 8'd10;
    localparam logic [7:0] RST_ALLOWED_VALUE_A = 8'h55;
    localparam logic [7:0] RST_ALLOWED_VALUE_B = 8'h67;
    localparam logic       RST_CHECK_TRAILING  = 1'b1;

    localparam logic [12:0] CNT13_MAX = 13'h1FFF;
    localparam logic [13:0] CNT14_MAX = 14'h3FFF;

    // Score terms
    localparam logic [7:0] SCORE_FULL      = 8'd100;
    localparam logic [4:0] BYTE_PENALTY_MAX = 5'd25;
    localparam logic [3:0] BAD_GAP_SAT     = 4'd13;
    localparam logic [3:0] BAD_END_SAT     = 4'd10;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam int CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_MIN_LENGTH = 2'd0,
        CFG_ALLOWED_VALUE_A = 2'd1,
        CFG_ALLOWED_VALUE_B = 2'd2,
        CFG_CHECK_TRAILING  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] sync_min_length;
        logic [7:0] allowed_value_a;
        logic [7:0] allowed_value_b;
        logic       check_trailing;
    } t_cfg;

    // One classified track byte
    typedef struct packed {
        logic is_ff;
        logic is_bad;
        logic is_trail;
        logic last;
    } t_cls;

    typedef struct packed {
        logic [13:0] bad_byte_total;
        logic [12:0] gaps_bad_ending;
        logic [12:0] gaps_with_bad_bytes;
        logic [12:0] gap_count;
    } t_totals;

    typedef struct packed {
        logic       undecided;
        logic [6:0] score;
        t_totals    tot;
    } t_result;

endpackage

// ----- design/sgfc_front.sv -----
// Front stage: registers each accepted track byte and classifies it.
// Depends on sgfc_pkg.
module sgfc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sgfc_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output logic              o_push,
    input  logic              i_room,
    output sgfc_pkg::t_cls    o_cls
);

    logic           r_valid;
    sgfc_pkg::t_cls r_cls;
    sgfc_pkg::t_cls n_cls;

    assign o_ready = !r_valid || i_room;
    assign o_push  = r_valid;
    assign o_cls   = r_cls;

    always_comb begin
        n_cls.is_ff    = (i_byte == sgfc_pkg::SYNC_BYTE);
        n_cls.is_bad   = (i_byte != i_cfg.allowed_value_a) &&
                         (i_byte != i_cfg.allowed_value_b);
        n_cls.is_trail = (i_byte == sgfc_pkg::TRAIL_BYTE);
        n_cls.last     = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready) begin
            r_cls <= n_cls;
        end
    end

endmodule

// ----- design/sgfc_fifo.sv -----
// Short queue of classified bytes between the front and the back stage.
// Depends on sgfc_pkg.
module sgfc_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_room,
    input  sgfc_pkg::t_cls i_data,
    output logic           o_valid,
    input  logic           i_pop,
    output sgfc_pkg::t_cls o_data
);

    sgfc_pkg::t_cls                 r_mem [sgfc_pkg::FIFO_DEPTH];
    logic [sgfc_pkg::FIFO_AW-1:0]   r_wr_ptr;
    logic [sgfc_pkg::FIFO_AW-1:0]   r_rd_ptr;
    logic [sgfc_pkg::FIFO_AW:0]     r_count;
    logic                           wr;
    logic                           rd;

    assign o_room  = (r_count != (sgfc_pkg::FIFO_AW+1)'(sgfc_pkg::FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr      = i_push && o_room;
    assign rd      = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({wr, rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
        if (wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (sgfc_pkg::FIFO_AW+1)'(sgfc_pkg::FIFO_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("empty queue with pointers apart");

endmodule

// ----- design/sgfc_back.sv -----
// Back stage: run/stretch tracking, gap totals, final score and output register.
// Depends on sgfc_pkg.
module sgfc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sgfc_pkg::t_cfg    i_cfg,
    input  logic              i_q_valid,
    input  sgfc_pkg::t_cls    i_q_data,
    output logic              o_q_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output sgfc_pkg::t_result o_result
);

    logic [7:0]          r_run_len;
    logic                r_in_run;
    logic                r_pend_ne;
    logic [13:0]         r_pend_bad;
    logic                r_pend_trail;
    sgfc_pkg::t_totals   r_tot;
    logic                r_fin_valid;
    sgfc_pkg::t_totals   r_fin;
    logic                r_out_valid;
    sgfc_pkg::t_result   r_out;

    logic [7:0]          n_run_len;
    logic                n_in_run;
    logic                n_pend_ne;
    logic [13:0]         n_pend_bad;
    logic                n_pend_trail;
    sgfc_pkg::t_totals   n_tot;
    sgfc_pkg::t_result   n_out;

    logic        out_adv;
    logic        fin_ready;
    logic [7:0]  need;
    logic [7:0]  len_inc;
    logic        judge;
    logic [7:0]  judge_len;
    logic        qualify;
    logic [13:0] bad_base;
    logic [14:0] sum_wide;
    logic [4:0]  byte_pen;
    logic [3:0]  bad_gap_s;
    logic [3:0]  bad_end_s;
    logic [7:0]  pen;

    assign out_adv   = !r_out_valid || i_ready;
    assign fin_ready = !r_fin_valid || out_adv;
    // Hold the final byte until the totals register is free
    assign o_q_pop   = i_q_valid && (!i_q_data.last || fin_ready);
    assign o_valid   = r_out_valid;
    assign o_result  = r_out;

    always_comb begin
        need    = (i_cfg.sync_min_length < sgfc_pkg::SYNC_MIN_FLOOR) ?
                  sgfc_pkg::SYNC_MIN_FLOOR : i_cfg.sync_min_length;
        len_inc = (r_run_len == 8'hFF) ? r_run_len : r_run_len + 8'd1;

        n_run_len    = r_run_len;
        n_in_run     = r_in_run;
        n_pend_ne    = r_pend_ne;
        n_pend_bad   = r_pend_bad;
        n_pend_trail = r_pend_trail;
        bad_base     = r_in_run ? '0 : r_pend_bad;

        if (i_q_data.is_ff) begin
            n_in_run  = 1'b1;
            n_run_len = r_in_run ? len_inc : 8'd1;
        end else begin
            n_in_run     = 1'b0;
            n_run_len    = '0;
            n_pend_ne    = 1'b1;
            n_pend_trail = i_q_data.is_trail;
            n_pend_bad   = (i_q_data.is_bad && bad_base != sgfc_pkg::CNT14_MAX) ?
                           bad_base + 14'd1 : bad_base;
        end

        // A run ends on a non-0xFF byte, or at the final byte if it is 0xFF
        judge     = i_q_data.is_ff ? i_q_data.last : r_in_run;
        judge_len = i_q_data.is_ff ? n_run_len : r_run_len;
        qualify   = judge && (judge_len >= need) && r_pend_ne;

        n_tot    = r_tot;
        sum_wide = {1'b0, r_tot.bad_byte_total} + {1'b0, r_pend_bad};
        if (qualify) begin
            if (r_tot.gap_count != sgfc_pkg::CNT13_MAX) begin
                n_tot.gap_count = r_tot.gap_count + 13'd1;
            end
            if (r_pend_bad != '0) begin
                if (r_tot.gaps_with_bad_bytes != sgfc_pkg::CNT13_MAX) begin
                    n_tot.gaps_with_bad_bytes = r_tot.gaps_with_bad_bytes + 13'd1;
                end
                n_tot.bad_byte_total = sum_wide[14] ? sgfc_pkg::CNT14_MAX :
                                       sum_wide[13:0];
            end
            if (i_cfg.check_trailing && !r_pend_trail &&
                r_tot.gaps_bad_ending != sgfc_pkg::CNT13_MAX) begin
                n_tot.gaps_bad_ending = r_tot.gaps_bad_ending + 13'd1;
            end
        end
    end

    // Score from the registered totals
    always_comb begin
        byte_pen  = (r_fin.bad_byte_total[13:3] > 11'(sgfc_pkg::BYTE_PENALTY_MAX)) ?
                    sgfc_pkg::BYTE_PENALTY_MAX : r_fin.bad_byte_total[7:3];
        bad_gap_s = (r_fin.gaps_with_bad_bytes > 13'(sgfc_pkg::BAD_GAP_SAT)) ?
                    sgfc_pkg::BAD_GAP_SAT : r_fin.gaps_with_bad_bytes[3:0];
        bad_end_s = (r_fin.gaps_bad_ending > 13'(sgfc_pkg::BAD_END_SAT)) ?
                    sgfc_pkg::BAD_END_SAT : r_fin.gaps_bad_ending[3:0];
        pen       = {1'b0, bad_gap_s, 3'b000} + {1'b0, bad_end_s, 3'b000} +
                    {3'b000, bad_end_s, 1'b0} + {3'b000, byte_pen};

        n_out.tot       = r_fin;
        n_out.undecided = (r_fin.gap_count == '0);
        if (n_out.undecided || pen >= sgfc_pkg::SCORE_FULL) begin
            n_out.score = '0;
        end else begin
            n_out.score = 7'(sgfc_pkg::SCORE_FULL - pen);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_len    <= '0;
            r_in_run     <= 1'b0;
            r_pend_ne    <= 1'b0;
            r_pend_bad   <= '0;
            r_pend_trail <= 1'b0;
            r_tot        <= '0;
            r_fin_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_q_pop) begin
                if (i_q_data.last) begin
                    // Clear all track state for the next track
                    r_run_len    <= '0;
                    r_in_run     <= 1'b0;
                    r_pend_ne    <= 1'b0;
                    r_pend_bad   <= '0;
                    r_pend_trail <= 1'b0;
                    r_tot        <= '0;
                end else begin
                    r_run_len    <= n_run_len;
                    r_in_run     <= n_in_run;
                    r_pend_ne    <= n_pend_ne;
                    r_pend_bad   <= n_pend_bad;
                    r_pend_trail <= n_pend_trail;
                    r_tot        <= n_tot;
                end
            end
            if (fin_ready) begin
                r_fin_valid <= o_q_pop && i_q_data.last;
            end
            if (out_adv) begin
                r_out_valid <= r_fin_valid;
            end
        end
        if (fin_ready && o_q_pop && i_q_data.last) begin
            r_fin <= n_tot;
        end
        if (out_adv && r_fin_valid) begin
            r_out <= n_out;
        end
    end

    a_score_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.score <= 7'(sgfc_pkg::SCORE_FULL)))
        else $error("score above full scale");

    a_undecided: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.undecided) |->
            (r_out.score == '0 && r_out.tot.gap_count == '0))
        else $error("undecided result with score or gaps");

    a_flawed_gap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tot.gaps_with_bad_bytes <= r_tot.gap_count)
        else $error("more bad gaps than gaps");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_q_data.last) |=> (r_tot == '0 && !r_in_run && !r_pend_ne))
        else $error("state not cleared after final byte");

endmodule

// ----- design/sync_gap_fill_checker.sv -----
// Top level of the sync gap fill checker: configuration registers, output packing.
// Depends on sgfc_pkg, sgfc_front, sgfc_fifo and sgfc_back.
// Throughput: one track byte per cycle while the byte queue has room.
// The result leaves through the totals register and then the output register.
// Reset (synchronous, active low) clears all counters and restores register defaults.
module sync_gap_fill_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] track_byte
    input  logic        s_axis_tlast,   // end_of_track
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [12:0] gap_count, [25:13] gaps_with_bad_bytes, [38:26] gaps_bad_ending,
    // [52:39] bad_byte_total, [59:53] score, [63:60] zero
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tuser    // undecided
);

    sgfc_pkg::t_cfg    r_cfg;
    sgfc_pkg::t_cls    front_cls;
    sgfc_pkg::t_cls    q_data;
    sgfc_pkg::t_result result;
    sgfc_pkg::t_cfg_idx cfg_idx;
    logic              front_push;
    logic              q_room;
    logic              q_valid;
    logic              q_pop;

    assign cfg_idx = sgfc_pkg::t_cfg_idx'(i_cfg_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_min_length <= sgfc_pkg::RST_SYNC_MIN_LENGTH;
            r_cfg.allowed_value_a <= sgfc_pkg::RST_ALLOWED_VALUE_A;
            r_cfg.allowed_value_b <= sgfc_pkg::RST_ALLOWED_VALUE_B;
            r_cfg.check_trailing  <= sgfc_pkg::RST_CHECK_TRAILING;
        end else if (i_cfg_wr_en) begin
            unique case (cfg_idx)
                sgfc_pkg::CFG_SYNC_MIN_LENGTH: r_cfg.sync_min_length <= i_cfg_data;
                sgfc_pkg::CFG_ALLOWED_VALUE_A: r_cfg.allowed_value_a <= i_cfg_data;
                sgfc_pkg::CFG_ALLOWED_VALUE_B: r_cfg.allowed_value_b <= i_cfg_data;
                sgfc_pkg::CFG_CHECK_TRAILING:  r_cfg.check_trailing  <= i_cfg_data[0];
                default:                       r_cfg <= r_cfg;
            endcase
        end
    end

    sgfc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .o_push  (front_push),
        .i_room  (q_room),
        .o_cls   (front_cls)
    );

    sgfc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .o_room  (q_room),
        .i_data  (front_cls),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_data)
    );

    sgfc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_result  (result)
    );

    assign m_axis_tdata = {4'b0000, result.score, result.tot.bad_byte_total,
                           result.tot.gaps_bad_ending, result.tot.gaps_with_bad_bytes,
                           result.tot.gap_count};
    assign m_axis_tuser = result.undecided;

endmodule

// ----- tb/tb_sync_gap_fill_checker.sv -----
// Self-checking bench for sync_gap_fill_checker: streams track bytes with random
// idling on both sides and checks every per-track summary against a built-in predictor or a directed expectation.
// Depends on sgfc_pkg and the sync_gap_fill_checker RTL.
module tb_sync_gap_fill_checker;

    typedef struct packed {
        logic [12:0] gaps;
        logic [12:0] flawed_gaps;
        logic [12:0] bad_ends;
        logic [13:0] flawed_bytes;
        logic [6:0]  score;
        logic        undecided;
    } t_track_summary;

    typedef struct packed {
        logic [7:0]     data;
        logic           eot;
        logic           typed;
        t_track_summary want;
    } t_dir_row;

    // Directed tracks, run with a sync minimum of 0 (acts as 2), values 0x55/0x67, trailing check on
    localparam int DIR_ROWS = 22;
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        '{8'h00, 1'b1, 1'b1, '{13'd0, 13'd0, 13'd0, 14'd0, 7'd0, 1'b1}},
        '{8'h67, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b1, 1'b1, '{13'd1, 13'd0, 13'd0, 14'd0, 7'd100, 1'b0}},
        '{8'h12, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h55, 1'b1, 1'b1, '{13'd1, 13'd1, 13'd1, 14'd1, 7'd82, 1'b0}},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h67, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h80, 1'b1, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'h67, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b1, 1'b0, '0},
        '{8'hFE, 1'b0, 1'b0, '0},
        '{8'h67, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b1, 1'b1, '{13'd1, 13'd1, 13'd0, 14'd1, 7'd92, 1'b0}}
    };

    localparam int HOLD_CYCLES = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;

    sync_gap_fill_checker uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Predictor copy of the registers and the track state
    logic [7:0]  min_len_cfg = sgfc_pkg::RST_SYNC_MIN_LENGTH;
    logic [7:0]  value_a_cfg = sgfc_pkg::RST_ALLOWED_VALUE_A;
    logic [7:0]  value_b_cfg = sgfc_pkg::RST_ALLOWED_VALUE_B;
    logic        trailing_cfg = sgfc_pkg::RST_CHECK_TRAILING;

    int unsigned run_len;
    bit          in_run;
    bit          stretch_open;
    int unsigned stretch_bad;
    logic [7:0]  stretch_last;
    int unsigned gaps_seen;
    int unsigned flawed_gaps_seen;
    int unsigned bad_ends_seen;
    int unsigned flawed_bytes_seen;

    t_track_summary pending_summaries[$];
    int  mismatches = 0;
    int  bytes_sent = 0;
    int  holds_asked = 0;
    int  holds_done = 0;
    int  hold_left = 0;
    int  stall_left = 0;
    int  stall_mode = 0;
    int  burst_left = 0;

    function automatic int unsigned sat(input int unsigned v, input int unsigned cap);
        return (v > cap) ? cap : v;
    endfunction

    function automatic void clear_track();
        run_len = 0;
        in_run = 1'b0;
        stretch_open = 1'b0;
        stretch_bad = 0;
        stretch_last = '0;
        gaps_seen = 0;
        flawed_gaps_seen = 0;
        bad_ends_seen = 0;
        flawed_bytes_seen = 0;
    endfunction

    // Judge the 0xFF run that just ended and clear the stretch state
    function automatic void judge_run();
        int unsigned need;
        need = (min_len_cfg < 2) ? 2 : 32'(min_len_cfg);
        if (run_len >= need && stretch_open) begin
            gaps_seen = sat(gaps_seen + 1, 32'(sgfc_pkg::CNT13_MAX));
            if (stretch_bad != 0) begin
                flawed_gaps_seen = sat(flawed_gaps_seen + 1, 32'(sgfc_pkg::CNT13_MAX));
                flawed_bytes_seen = sat(flawed_bytes_seen + stretch_bad,
                                        32'(sgfc_pkg::CNT14_MAX));
            end
            if (trailing_cfg && stretch_last != sgfc_pkg::TRAIL_BYTE)
                bad_ends_seen = sat(bad_ends_seen + 1, 32'(sgfc_pkg::CNT13_MAX));
        end
        in_run = 1'b0;
        run_len = 0;
        stretch_open = 1'b0;
        stretch_bad = 0;
        stretch_last = '0;
    endfunction

    function automatic bit scan_track_byte(input logic [7:0] b, input logic eot,
                                           output t_track_summary res);
        int unsigned byte_pen;
        int unsigned pen;
        res = '0;
        if (b == sgfc_pkg::SYNC_BYTE) begin
            run_len = in_run ? sat(run_len + 1, 255) : 1;
            in_run = 1'b1;
        end else begin
            if (in_run)
                judge_run();
            stretch_open = 1'b1;
            if (b != value_a_cfg && b != value_b_cfg)
                stretch_bad = sat(stretch_bad + 1, 32'(sgfc_pkg::CNT14_MAX));
            stretch_last = b;
        end
        if (!eot)
            return 1'b0;
        if (in_run)
            judge_run();
        res.gaps = 13'(gaps_seen);
        res.flawed_gaps = 13'(flawed_gaps_seen);
        res.bad_ends = 13'(bad_ends_seen);
        res.flawed_bytes = 14'(flawed_bytes_seen);
        res.undecided = (gaps_seen == 0);
        if (gaps_seen == 0) begin
            res.score = '0;
        end else begin
            byte_pen = flawed_bytes_seen / 8;
            if (byte_pen > 25)
                byte_pen = 25;
            pen = flawed_gaps_seen * 8 + bad_ends_seen * 10 + byte_pen;
            res.score = (pen >= 100) ? 7'd0 : 7'(100 - pen);
        end
        clear_track();
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Offer one byte, wait for its transfer, then predict
    task automatic put_byte(input logic [7:0] b, input logic eot, input bit typed,
                            input t_track_summary want);
        t_track_summary res;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= eot;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
        if (scan_track_byte(b, eot, res))
            pending_summaries.push_back(typed ? want : res);
    endtask

    task automatic send(input logic [7:0] b, input logic eot);
        put_byte(b, eot, 1'b0, '0);
    endtask

    // Let every expected summary arrive, then leave the block quiet
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_summaries.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [7:0] min_len, input logic [7:0] val_a,
                                 input logic [7:0] val_b, input logic trailing);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= sgfc_pkg::CFG_SYNC_MIN_LENGTH;
        i_cfg_data <= min_len;
        @(posedge i_clk);
        i_cfg_index <= sgfc_pkg::CFG_ALLOWED_VALUE_A;
        i_cfg_data <= val_a;
        @(posedge i_clk);
        i_cfg_index <= sgfc_pkg::CFG_ALLOWED_VALUE_B;
        i_cfg_data <= val_b;
        @(posedge i_clk);
        i_cfg_index <= sgfc_pkg::CFG_CHECK_TRAILING;
        i_cfg_data <= {7'd0, trailing};
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        min_len_cfg = min_len;
        value_a_cfg = val_a;
        value_b_cfg = val_b;
        trailing_cfg = trailing;
    endtask

    function automatic logic [7:0] gap_fill_byte();
        int unsigned pick;
        logic [7:0] v;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            v = value_a_cfg;
        else if (pick < 7)
            v = value_b_cfg;
        else
            v = 8'($urandom_range(0, 255));
        if (v == sgfc_pkg::SYNC_BYTE)
            v = 8'($urandom_range(0, 254));
        return v;
    endfunction

    // Mostly gap + sync pairs with random content, some raw noise, then the final byte
    task automatic send_random_track(input int span);
        int sent;
        int need;
        int n;
        logic [7:0] v;
        sent = 0;
        need = (min_len_cfg < 2) ? 2 : 32'(min_len_cfg);
        while (sent < span) begin
            if ($urandom_range(0, 9) < 7) begin
                n = $urandom_range(1, 5);
                for (int k = 0; k < n; k++) begin
                    v = gap_fill_byte();
                    if (k == n - 1 && $urandom_range(0, 9) < 7)
                        v = sgfc_pkg::TRAIL_BYTE;
                    send(v, 1'b0);
                end
                sent += n;
                n = need + $urandom_range(0, 3) - 1;
                if (n < 1)
                    n = 1;
                repeat (n) send(sgfc_pkg::SYNC_BYTE, 1'b0);
                sent += n;
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) send(8'($urandom_range(0, 255)), 1'b0);
                sent += n;
            end
        end
        if ($urandom_range(0, 2) == 0)
            send(sgfc_pkg::SYNC_BYTE, 1'b1);
        else
            send(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Receiver: long hold-offs on request, otherwise stretches of varied stalling
    always @(posedge i_clk) begin
        if (holds_done < holds_asked) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                stall_left = $urandom_range(5, 60);
            end
            stall_left--;
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_track_summary want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_summaries.size() == 0) begin
                flag_mismatch("unexpected summary, gap_count",
                              longint'(m_axis_tdata[12:0]), longint'(0));
            end else begin
                want = pending_summaries.pop_front();
                if (m_axis_tdata[12:0] !== want.gaps)
                    flag_mismatch("gap_count", longint'(m_axis_tdata[12:0]),
                                  longint'(want.gaps));
                if (m_axis_tdata[25:13] !== want.flawed_gaps)
                    flag_mismatch("gaps_with_bad_bytes", longint'(m_axis_tdata[25:13]),
                                  longint'(want.flawed_gaps));
                if (m_axis_tdata[38:26] !== want.bad_ends)
                    flag_mismatch("gaps_bad_ending", longint'(m_axis_tdata[38:26]),
                                  longint'(want.bad_ends));
                if (m_axis_tdata[52:39] !== want.flawed_bytes)
                    flag_mismatch("bad_byte_total", longint'(m_axis_tdata[52:39]),
                                  longint'(want.flawed_bytes));
                if (m_axis_tdata[59:53] !== want.score)
                    flag_mismatch("score", longint'(m_axis_tdata[59:53]),
                                  longint'(want.score));
                if (m_axis_tdata[63:60] !== 4'd0)
                    flag_mismatch("tdata pad", longint'(m_axis_tdata[63:60]), longint'(0));
                if (m_axis_tuser !== want.undecided)
                    flag_mismatch("undecided", longint'(m_axis_tuser),
                                  longint'(want.undecided));
            end
        end
    end

    initial begin
        #50_000_000;
        $display("sync_gap_fill_checker: mismatch");
        $finish;
    end

    initial begin
        int phase_start;
        clear_track();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        load_settings(8'd0, 8'h55, 8'h67, 1'b1);
        for (int r = 0; r < DIR_ROWS; r++)
            put_byte(DIRECTED[r].data, DIRECTED[r].eot, DIRECTED[r].typed, DIRECTED[r].want);
        drain();

        // Longest minimum: run length saturates exactly at the threshold
        load_settings(8'd255, 8'hAA, 8'h67, 1'b1);
        send(8'h67, 1'b0);
        repeat (255) send(sgfc_pkg::SYNC_BYTE, 1'b0);
        send(8'h00, 1'b1);
        send(8'h67, 1'b0);
        repeat (253) send(sgfc_pkg::SYNC_BYTE, 1'b0);
        send(sgfc_pkg::SYNC_BYTE, 1'b1);
        send(8'h55, 1'b0);
        repeat (260) send(sgfc_pkg::SYNC_BYTE, 1'b0);
        send(sgfc_pkg::SYNC_BYTE, 1'b1);
        drain();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: load_settings(sgfc_pkg::RST_SYNC_MIN_LENGTH, sgfc_pkg::RST_ALLOWED_VALUE_A,
                                 sgfc_pkg::RST_ALLOWED_VALUE_B, sgfc_pkg::RST_CHECK_TRAILING);
                1: load_settings(8'd1, 8'h00, 8'hFF, 1'b0);
                2: load_settings(8'd0, 8'hFF, 8'h00, 1'b1);
                default: load_settings(8'($urandom_range(0, 6)),
                                       $urandom_range(0, 1) ? 8'h55 : 8'($urandom_range(0, 255)),
                                       $urandom_range(0, 1) ? 8'h67 : 8'($urandom_range(0, 255)),
                                       1'($urandom_range(0, 1)));
            endcase
            phase_start = bytes_sent;
            if (p == 4) begin
                // Short tracks against a stalled receiver fill the result registers and back up the byte queue
                holds_asked++;
                repeat (14) send_random_track($urandom_range(0, 2));
            end
            while (bytes_sent - phase_start < 20)
                send_random_track(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(4, 40));
            drain();
        end

        s_axis_tvalid <= 1'b0;
        while (pending_summaries.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        if (mismatches == 0)
            $display("sync_gap_fill_checker: match");
        else
            $display("sync_gap_fill_checker: mismatch");
        $finish;
    end

endmodule
